### rtl/smm_pkg.sv
package smm_pkg;

    // default matrix size and the widest element index the design supports
    localparam int MATRIX_SIZE_DEF = 4;
    localparam int KEY_W           = 3;

    // command codes of the input word
    localparam logic [1:0] CMD_LOAD_A   = 2'd0;
    localparam logic [1:0] CMD_LOAD_B   = 2'd1;
    localparam logic [1:0] CMD_MULTIPLY = 2'd2;

    typedef struct packed {
        logic [1:0]         command;
        logic [1:0]         row_index;
        logic [1:0]         col_index;
        logic signed [15:0] element_value;
    } smm_in_t;

    typedef struct packed {
        logic [1:0]         out_row;
        logic [1:0]         out_col;
        logic signed [31:0] product_value;
        logic               last_element;
    } smm_out_t;

    // element of A traveling down the cell chain
    typedef struct packed {
        logic               vld;
        logic               first;
        logic [KEY_W-1:0]   k;
        logic signed [15:0] a;
    } smm_tok_t;

    // broadcast write of one element of B
    typedef struct packed {
        logic               en;
        logic [KEY_W-1:0]   row;
        logic [KEY_W-1:0]   col;
        logic signed [15:0] data;
    } smm_bwr_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FEED,
        ST_DRAIN,
        ST_EMIT
    } smm_state_t;

endpackage

### rtl/smm_cell.sv
module smm_cell
    import smm_pkg::*;
#(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF,
    parameter int CELL_COL    = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  smm_bwr_t           bwr_i,
    input  smm_tok_t           tok_i,
    output smm_tok_t           tok_o,
    output logic signed [31:0] acc_o
);

    localparam int IDX_W = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;

    logic signed [15:0] b_mem [MATRIX_SIZE];
    logic signed [15:0] b_rd_reg;
    logic signed [15:0] a_s1_reg;
    logic               v1_reg;
    logic               f1_reg;
    logic signed [31:0] prod_reg;
    logic               v2_reg;
    logic               f2_reg;
    logic signed [31:0] acc_reg;
    smm_tok_t           tok_reg;

    // store this cell's column of B, read the row that the word asks for
    always_ff @(posedge aclk) begin
        if (bwr_i.en && bwr_i.col == KEY_W'(CELL_COL)) begin
            b_mem[bwr_i.row[IDX_W-1:0]] <= bwr_i.data;
        end
        b_rd_reg <= b_mem[tok_i.k[IDX_W-1:0]];
        a_s1_reg <= tok_i.a;
        f1_reg   <= tok_i.first;
        prod_reg <= a_s1_reg * b_rd_reg;
        f2_reg   <= f1_reg;
    end

    // pass the A element to the neighbor, track stage valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            tok_reg <= tok_i;
            v1_reg  <= tok_i.vld;
            v2_reg  <= v1_reg;
        end
    end

    // accumulate, restart on the first product of a row
    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            acc_reg <= f2_reg ? prod_reg : acc_reg + prod_reg;
        end
    end

    assign tok_o = tok_reg;
    assign acc_o = acc_reg;

endmodule

### rtl/square_matrix_multiply.sv
// Square matrix multiplier, C = A * B on signed 16-bit elements, results wrapped
// to 32 bits. Load words write one element of A or B (loads outside the matrix
// and the unused command are dropped). A multiply word emits all MATRIX_SIZE^2
// elements of C in row-major order, last one flagged. Every element must be
// loaded before a multiply reads it. Each row of C is built by a chain of
// MATRIX_SIZE cells, one per column, each holding its column of B; A is read from
// one memory port one element a cycle and walks the chain. Each row is fed,
// drained through the chain and then emitted, and a multiply holds s_ready low
// until the last element of C has been emitted.
module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  smm_in_t  s_word,
    output logic     m_valid,
    input  logic     m_ready,
    output smm_out_t m_word
);

    localparam int IDX_W      = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
    localparam int ADDR_W     = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE * MATRIX_SIZE) : 1;
    localparam int DRAIN_LAST = MATRIX_SIZE + 2;
    localparam int DRN_W      = $clog2(DRAIN_LAST + 1);

    smm_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   row_reg, row_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [DRN_W-1:0]   drain_reg, drain_next;
    logic               m_valid_reg, m_valid_next;
    smm_out_t           m_word_reg;

    logic signed [15:0] a_mem [MATRIX_SIZE * MATRIX_SIZE];
    logic signed [15:0] a_rd_reg;
    smm_tok_t           head_reg;

    logic               accept;
    logic               load_ok;
    logic               a_we;
    logic               start;
    logic               issue;
    logic               emit;
    logic               last_step;
    logic               last_row;
    logic               drain_done;
    logic [ADDR_W-1:0]  wr_addr;
    logic [ADDR_W-1:0]  rd_addr;
    smm_bwr_t           bwr;
    smm_tok_t           tok_w [MATRIX_SIZE];
    logic signed [31:0] acc_w [MATRIX_SIZE];

    // decode the input word and the sequencing conditions
    always_comb begin
        accept     = s_valid && s_ready;
        load_ok    = (32'(s_word.row_index) < MATRIX_SIZE)
                     && (32'(s_word.col_index) < MATRIX_SIZE);
        a_we       = accept && load_ok && s_word.command == CMD_LOAD_A;
        start      = accept && s_word.command == CMD_MULTIPLY;
        last_step  = step_reg == IDX_W'(MATRIX_SIZE - 1);
        last_row   = row_reg == IDX_W'(MATRIX_SIZE - 1);
        drain_done = drain_reg == DRN_W'(DRAIN_LAST);
        wr_addr    = ADDR_W'(s_word.row_index) * ADDR_W'(MATRIX_SIZE)
                     + ADDR_W'(s_word.col_index);
        rd_addr    = ADDR_W'(row_reg) * ADDR_W'(MATRIX_SIZE) + ADDR_W'(step_reg);
        bwr.en     = accept && load_ok && s_word.command == CMD_LOAD_B;
        bwr.row    = KEY_W'(s_word.row_index);
        bwr.col    = KEY_W'(s_word.col_index);
        bwr.data   = s_word.element_value;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next = ST_FEED;
                end
            end
            ST_FEED: begin
                if (last_step) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (drain_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (emit && last_step) begin
                    state_next = last_row ? ST_IDLE : ST_FEED;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs and counters
    always_comb begin
        s_ready      = 1'b0;
        issue        = 1'b0;
        emit         = 1'b0;
        row_next     = row_reg;
        step_next    = step_reg;
        drain_next   = drain_reg;
        m_valid_next = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid && s_word.command == CMD_MULTIPLY) begin
                    row_next  = '0;
                    step_next = '0;
                end
            end
            ST_FEED: begin
                issue      = 1'b1;
                drain_next = '0;
                step_next  = last_step ? '0 : step_reg + 1'b1;
            end
            ST_DRAIN: begin
                drain_next = drain_reg + 1'b1;
            end
            ST_EMIT: begin
                emit = !m_valid_reg || m_ready;
                if (emit) begin
                    m_valid_next = 1'b1;
                    step_next    = last_step ? '0 : step_reg + 1'b1;
                    if (last_step && !last_row) begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            row_reg     <= '0;
            step_reg    <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
            head_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            row_reg      <= row_next;
            step_reg     <= step_next;
            drain_reg    <= drain_next;
            m_valid_reg  <= m_valid_next;
            head_reg.vld   <= issue;
            head_reg.first <= step_reg == '0;
            head_reg.k     <= KEY_W'(step_reg);
            head_reg.a     <= '0;
        end
    end

    // A store: write on load, read one element a cycle for the chain
    always_ff @(posedge aclk) begin
        if (a_we) begin
            a_mem[wr_addr] <= s_word.element_value;
        end
        a_rd_reg <= a_mem[rd_addr];
    end

    // hold the result word until taken
    always_ff @(posedge aclk) begin
        if (emit) begin
            m_word_reg.out_row       <= 2'(row_reg);
            m_word_reg.out_col       <= 2'(step_reg);
            m_word_reg.product_value <= acc_w[step_reg];
            m_word_reg.last_element  <= last_row && last_step;
        end
    end

    // cell chain, one cell per column of C
    always_comb begin
        tok_w[0]   = head_reg;
        tok_w[0].a = a_rd_reg;
    end

    for (genvar j = 0; j < MATRIX_SIZE; j++) begin : g_cell
        if (j < MATRIX_SIZE - 1) begin : g_mid
            smm_cell #(
                .MATRIX_SIZE (MATRIX_SIZE),
                .CELL_COL    (j)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .bwr_i   (bwr),
                .tok_i   (tok_w[j]),
                .tok_o   (tok_w[j+1]),
                .acc_o   (acc_w[j])
            );
        end else begin : g_end
            smm_cell #(
                .MATRIX_SIZE (MATRIX_SIZE),
                .CELL_COL    (j)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .bwr_i   (bwr),
                .tok_i   (tok_w[j]),
                .tok_o   (),
                .acc_o   (acc_w[j])
            );
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

endmodule

### rtl/smm_checker.sv
module smm_sva_checker
    import smm_pkg::*;
#(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input smm_in_t  s_word,
    input logic     m_valid,
    input logic     m_ready,
    input smm_out_t m_word
);

    // no result word comes out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // a multiply word closes the input while it runs
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.command == CMD_MULTIPLY |=> !s_ready)
        else $error("input open right after a multiply");

    // a load never makes a result word
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_word.command != CMD_MULTIPLY && !m_valid |=> !m_valid)
        else $error("result word after a load");

    // the flagged word sits at the last row and column
    a_last_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.last_element |->
            m_word.out_row == 2'(MATRIX_SIZE - 1) && m_word.out_col == 2'(MATRIX_SIZE - 1))
        else $error("last word not at the final element");

endmodule

bind square_matrix_multiply smm_sva_checker #(.MATRIX_SIZE(MATRIX_SIZE)) u_smm_checker (.*);

### test/smm_checker.sv
`timescale 1ns / 1ps

module smm_checker
    import smm_pkg::*;
#(
    parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_ready,
    input  smm_in_t  s_word,
    input  logic     m_valid,
    input  logic     m_ready,
    input  smm_out_t m_word,
    output int       fail_count,
    output int       pending_words,
    output int       checked_words
);

    localparam int PRINT_CAP = 30;

    // shadow copies of both operand matrices
    logic signed [15:0] a_store [MATRIX_SIZE][MATRIX_SIZE];
    logic signed [15:0] b_store [MATRIX_SIZE][MATRIX_SIZE];

    // product words still owed by the block, oldest first
    smm_out_t product_q[$];

    initial begin
        fail_count    = 0;
        pending_words = 0;
        checked_words = 0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("%0t ns: product check: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    // one element of C, every product and sum wrapped to 32 bits
    function automatic logic signed [31:0] dot_row_col(input int i, input int j);
        logic signed [31:0] acc;
        acc = '0;
        for (int k = 0; k < MATRIX_SIZE; k++) begin
            acc = acc + a_store[i][k] * b_store[k][j];
        end
        return acc;
    endfunction

    // queue the whole product matrix in row-major order
    task automatic queue_product();
        smm_out_t w;
        for (int i = 0; i < MATRIX_SIZE; i++) begin
            for (int j = 0; j < MATRIX_SIZE; j++) begin
                w.out_row       = 2'(i);
                w.out_col       = 2'(j);
                w.product_value = dot_row_col(i, j);
                w.last_element  = (i == MATRIX_SIZE - 1) && (j == MATRIX_SIZE - 1);
                product_q.push_back(w);
            end
        end
    endtask

    task automatic check_product(input smm_out_t got);
        smm_out_t want;
        if (product_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word row %0d col %0d value %0d",
                got.out_row, got.out_col, got.product_value));
            return;
        end
        want = product_q.pop_front();
        checked_words++;
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("out_row %0d, want %0d", got.out_row, want.out_row));
        if (got.out_col !== want.out_col)
            report_mismatch($sformatf("out_col %0d, want %0d", got.out_col, want.out_col));
        if (got.product_value !== want.product_value)
            report_mismatch($sformatf("C[%0d][%0d] = %0d, want %0d", want.out_row,
                want.out_col, got.product_value, want.product_value));
        if (got.last_element !== want.last_element)
            report_mismatch($sformatf("last_element %0b at C[%0d][%0d], want %0b",
                got.last_element, want.out_row, want.out_col, want.last_element));
    endtask

    // check outgoing words, then update the shadow state from incoming ones
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                check_product(m_word);
            end
            if (s_valid && s_ready) begin
                case (s_word.command)
                    CMD_LOAD_A: begin
                        if (int'(s_word.row_index) < MATRIX_SIZE &&
                            int'(s_word.col_index) < MATRIX_SIZE)
                            a_store[s_word.row_index][s_word.col_index] = s_word.element_value;
                    end
                    CMD_LOAD_B: begin
                        if (int'(s_word.row_index) < MATRIX_SIZE &&
                            int'(s_word.col_index) < MATRIX_SIZE)
                            b_store[s_word.row_index][s_word.col_index] = s_word.element_value;
                    end
                    CMD_MULTIPLY: queue_product();
                    default: ;
                endcase
            end
        end
        pending_words <= product_q.size();
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps

module tb;
    import smm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int N             = MATRIX_SIZE_DEF;
    localparam int RESET_CYCLES  = 7;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 80;
    localparam int PHASE_WORDS   = 67;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    smm_in_t  s_word  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    smm_out_t m_word;

    int fail_count;
    int pending_words;
    int checked_words;

    int idle_pct  = 0;
    int stall_pct = 0;
    logic hold_go = 1'b0;
    logic rx_hold = 1'b0;
    int words_sent = 0;

    always #1 aclk = ~aclk;

    square_matrix_multiply dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_word  (s_word),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

    smm_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_word        (s_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word),
        .fail_count    (fail_count),
        .pending_words (pending_words),
        .checked_words (checked_words)
    );

    // stall the result side at random, or hard during a hold-off
    always @(posedge aclk) begin
        m_ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
    end

    // long output hold-off, counted here so the sender keeps offering words
    initial begin
        wait (hold_go);
        @(posedge aclk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        rx_hold <= 1'b0;
    end

    // give up on a hung run
    initial begin
        #400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic smm_in_t make_word(input logic [1:0] cmd, input logic [1:0] r,
                                          input logic [1:0] c, input logic signed [15:0] v);
        smm_in_t w;
        w.command       = cmd;
        w.row_index     = r;
        w.col_index     = c;
        w.element_value = v;
        return w;
    endfunction

    // mostly random values, with the extremes mixed in
    function automatic logic signed [15:0] pick_value();
        case ($urandom_range(15))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd0;
            4: return 16'sd1;
            default: return 16'($urandom);
        endcase
    endfunction

    // offer one word, with a random gap first; hold valid until accepted
    task automatic send_word(input smm_in_t w);
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < idle_pct) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
    endtask

    task automatic send_random_word();
        int pick;
        logic [1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 40)      cmd = CMD_LOAD_A;
        else if (pick < 80) cmd = CMD_LOAD_B;
        else if (pick < 92) cmd = CMD_MULTIPLY;
        else                cmd = CMD_UNUSED;
        send_word(make_word(cmd, 2'($urandom), 2'($urandom), pick_value()));
    endtask

    // drop valid and hold until every owed product word has come back
    task automatic drain_products();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending_words != 0) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // every entry at the negative extreme: each sum wraps to zero
        for (int r = 0; r < N; r++) begin
            for (int c = 0; c < N; c++) begin
                send_word(make_word(CMD_LOAD_A, 2'(r), 2'(c), 16'sh8000));
                send_word(make_word(CMD_LOAD_B, 2'(r), 2'(c), 16'sh8000));
            end
        end
        send_word(make_word(CMD_MULTIPLY, 2'd3, 2'd3, 16'sh8000));

        // unused command, then mixed extremes and a multiply with odd ignored fields
        send_word(make_word(CMD_UNUSED, 2'd3, 2'd3, 16'sh7fff));
        send_word(make_word(CMD_LOAD_A, 2'd0, 2'd0, 16'sh7fff));
        send_word(make_word(CMD_LOAD_A, 2'd3, 2'd3, -16'sd1));
        send_word(make_word(CMD_LOAD_B, 2'd0, 2'd3, 16'sd1));
        send_word(make_word(CMD_LOAD_B, 2'd3, 2'd0, 16'sd0));
        send_word(make_word(CMD_LOAD_B, 2'd3, 2'd3, 16'sh7fff));
        send_word(make_word(CMD_MULTIPLY, 2'd0, 2'd0, 16'sd0));

        // random part, one flow-control setting per phase
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin idle_pct = 0;  stall_pct <= 0;  end
                1: begin idle_pct = 46; stall_pct <= 0;  end
                2: begin idle_pct = 0;  stall_pct <= 46; end
                default: begin idle_pct = 18; stall_pct <= 18; end
            endcase
            if (ph == 0) begin
                hold_go = 1'b1;
                send_word(make_word(CMD_MULTIPLY, 2'd1, 2'd2, 16'sh1234));
            end
            repeat (PHASE_WORDS) send_random_word();
            if (ph == 1) drain_products();
        end

        drain_products();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d input words: loads of A and B, multiplies, unused command.",
            words_sent);
        $display("%0d product words checked across four flow-control phases and a hold-off.",
            checked_words);
        if (fail_count == 0 && pending_words == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
